// ===== rtl/cse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_pkg: shared types and constants of the Chebyshev series evaluator
// Fixed-point widths, microcode control word and the microcode ROM.
// ----------------------------------------------------------------------------
package cse_pkg;

	// fixed-point format
	localparam int X_FRAC_BITS = 16;
	localparam int ACC_WIDTH   = 48;
	localparam int X_W         = X_FRAC_BITS + 2;
	localparam int COEF_W      = 32;
	localparam int SUM_W       = 48;
	localparam int PROD_W      = COEF_W + X_W;
	localparam int ONE_X       = 1 << X_FRAC_BITS;
	localparam int X_HALF      = 1 << (X_FRAC_BITS - 1);

	// series position: order 0, order 1, order 2 and up
	typedef enum logic [1:0] {
		PH_ORDER0 = 2'd0,
		PH_ORDER1 = 2'd1,
		PH_RECUR  = 2'd2
	} phase_t;

	// sequencer steps (program addresses)
	typedef enum logic [2:0] {
		STEP_FETCH = 3'd0,
		STEP_REC   = 3'd1,
		STEP_TSEL  = 3'd2,
		STEP_MULT  = 3'd3,
		STEP_ACC   = 3'd4
	} step_t;

	// multiplier operand selection
	typedef enum logic [1:0] {
		MUL_NONE = 2'd0,
		MUL_REC  = 2'd1,
		MUL_TERM = 2'd2
	} mul_sel_t;

	// hold conditions: while true the sequencer stays on the step
	typedef enum logic [1:0] {
		HOLD_NEVER   = 2'd0,
		HOLD_NO_IN   = 2'd1,
		HOLD_OUT_BSY = 2'd2
	} hold_t;

	typedef struct packed {
		logic     fetch;
		mul_sel_t mul_sel;
		logic     t_upd;
		logic     acc_upd;
		hold_t    hold;
		step_t    next;
	} ucode_t;

	// control from sequencer to datapath
	typedef struct packed {
		logic     load_in;
		mul_sel_t mul_sel;
		logic     t_upd;
		logic     acc_upd;
	} dp_ctrl_t;

	// microcode ROM
	function automatic ucode_t ucode_rom(step_t step);
		ucode_t w;
		w = '{fetch: 1'b0, mul_sel: MUL_NONE, t_upd: 1'b0, acc_upd: 1'b0,
			hold: HOLD_NEVER, next: STEP_FETCH};
		unique case (step)
			STEP_FETCH: begin
				w.fetch = 1'b1;
				w.hold  = HOLD_NO_IN;
				w.next  = STEP_REC;
			end
			STEP_REC: begin
				w.mul_sel = MUL_REC;
				w.next    = STEP_TSEL;
			end
			STEP_TSEL: begin
				w.t_upd = 1'b1;
				w.next  = STEP_MULT;
			end
			STEP_MULT: begin
				w.mul_sel = MUL_TERM;
				w.next    = STEP_ACC;
			end
			STEP_ACC: begin
				w.acc_upd = 1'b1;
				w.hold    = HOLD_OUT_BSY;
				w.next    = STEP_FETCH;
			end
			default: begin
				w.next = STEP_FETCH;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/cse_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_in_if / cse_out_if: valid/ready channels of the series evaluator
// Input carries one coefficient per transaction, output one series sum.
// ----------------------------------------------------------------------------
interface cse_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [cse_pkg::X_W-1:0]     x_value;
	logic signed [cse_pkg::COEF_W-1:0]  coefficient;
	logic                               last_term;

	modport source (output valid, output x_value, output coefficient,
		output last_term, input ready);
	modport sink (input valid, input x_value, input coefficient,
		input last_term, output ready);
endinterface

interface cse_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [cse_pkg::SUM_W-1:0]   series_sum;
	logic                               overflow;

	modport source (output valid, output series_sum, output overflow, input ready);
	modport sink (input valid, input series_sum, input overflow, output ready);
endinterface

// ===== rtl/cse_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_datapath: recurrence and multiply-accumulate datapath
// One shared 32x18 multiplier, T recurrence registers, saturating accumulator.
// ----------------------------------------------------------------------------
module cse_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cse_pkg::dp_ctrl_t                     ctrl,
	input  logic signed [cse_pkg::X_W-1:0]        x_value,
	input  logic signed [cse_pkg::COEF_W-1:0]     coefficient,
	input  logic                                  last_term,
	output logic                                  last,
	output logic signed [cse_pkg::ACC_WIDTH-1:0]  acc_next,
	output logic                                  ovf_next
);

	localparam int REC_W = cse_pkg::PROD_W + 2;
	localparam int TRM_W = cse_pkg::PROD_W + 1;
	localparam int ADD_W = ((cse_pkg::ACC_WIDTH > TRM_W) ? cse_pkg::ACC_WIDTH : TRM_W) + 2;
	localparam logic signed [ADD_W-1:0] ACC_MAX =
		ADD_W'({1'b0, {(cse_pkg::ACC_WIDTH-1){1'b1}}});
	localparam logic signed [ADD_W-1:0] ACC_MIN = -ACC_MAX - ADD_W'(1);

	cse_pkg::phase_t                        phase_q;
	logic signed [cse_pkg::X_W-1:0]         held_x_q;
	logic signed [cse_pkg::X_W-1:0]         prev_q;
	logic signed [cse_pkg::X_W-1:0]         prev2_q;
	logic signed [cse_pkg::COEF_W-1:0]      coef_q;
	logic                                   last_q;
	logic signed [cse_pkg::PROD_W-1:0]      prod_q;
	logic signed [cse_pkg::ACC_WIDTH-1:0]   acc_q;
	logic                                   ovf_q;

	logic signed [cse_pkg::X_W-1:0]         x_clamped;
	logic signed [cse_pkg::COEF_W-1:0]      mul_a;
	logic signed [REC_W-1:0]                rec_sum;
	logic signed [REC_W-1:0]                rec_t;
	logic signed [cse_pkg::X_W-1:0]         rec_clamped;
	logic signed [cse_pkg::X_W-1:0]         t_val;
	logic signed [TRM_W-1:0]                trm_sum;
	logic signed [TRM_W-1:0]                term;
	logic signed [ADD_W-1:0]                acc_sum;

	// x limited to [-1,1]
	always_comb begin
		if (x_value > cse_pkg::X_W'(cse_pkg::ONE_X))
			x_clamped = cse_pkg::X_W'(cse_pkg::ONE_X);
		else if (x_value < -cse_pkg::X_W'(cse_pkg::ONE_X))
			x_clamped = -cse_pkg::X_W'(cse_pkg::ONE_X);
		else
			x_clamped = x_value;
	end

	// recurrence: round(2*x*T[i-1]) - T[i-2], clamped to [-1,1]
	always_comb begin
		rec_sum = (REC_W'(prod_q) <<< 1) + REC_W'(cse_pkg::X_HALF);
		rec_t   = (rec_sum >>> cse_pkg::X_FRAC_BITS) - REC_W'(prev2_q);
		if (rec_t > REC_W'(cse_pkg::ONE_X))
			rec_clamped = cse_pkg::X_W'(cse_pkg::ONE_X);
		else if (rec_t < -REC_W'(cse_pkg::ONE_X))
			rec_clamped = -cse_pkg::X_W'(cse_pkg::ONE_X);
		else
			rec_clamped = cse_pkg::X_W'(rec_t);
	end

	// T of the current order
	always_comb begin
		unique case (phase_q)
			cse_pkg::PH_ORDER0: t_val = cse_pkg::X_W'(cse_pkg::ONE_X);
			cse_pkg::PH_ORDER1: t_val = held_x_q;
			default:            t_val = rec_clamped;
		endcase
	end

	// shared multiplier operand; second operand is always T[i-1] / T[i]
	always_comb begin
		case (ctrl.mul_sel)
			cse_pkg::MUL_TERM: mul_a = coef_q;
			default:           mul_a = cse_pkg::COEF_W'(held_x_q);
		endcase
	end

	// rounded term and saturating add
	always_comb begin
		trm_sum = TRM_W'(prod_q) + TRM_W'(cse_pkg::X_HALF);
		term    = trm_sum >>> cse_pkg::X_FRAC_BITS;
		acc_sum = ADD_W'(acc_q) + ADD_W'(term);
		ovf_next = ovf_q;
		if (acc_sum > ACC_MAX) begin
			acc_next = cse_pkg::ACC_WIDTH'(ACC_MAX);
			ovf_next = 1'b1;
		end else if (acc_sum < ACC_MIN) begin
			acc_next = cse_pkg::ACC_WIDTH'(ACC_MIN);
			ovf_next = 1'b1;
		end else begin
			acc_next = cse_pkg::ACC_WIDTH'(acc_sum);
		end
	end

	assign last = last_q;

	// control and recurrence state: phase, held x, T history, accumulator, sticky flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= cse_pkg::PH_ORDER0;
			held_x_q <= '0;
			prev_q   <= '0;
			prev2_q  <= '0;
			acc_q    <= '0;
			ovf_q    <= 1'b0;
		end else begin
			if (ctrl.load_in && phase_q == cse_pkg::PH_ORDER0)
				held_x_q <= x_clamped;
			if (ctrl.t_upd) begin
				prev_q  <= t_val;
				prev2_q <= prev_q;
				if (phase_q == cse_pkg::PH_ORDER0)
					phase_q <= cse_pkg::PH_ORDER1;
				else
					phase_q <= cse_pkg::PH_RECUR;
			end
			if (ctrl.acc_upd) begin
				if (last_q) begin
					acc_q   <= '0;
					ovf_q   <= 1'b0;
					phase_q <= cse_pkg::PH_ORDER0;
				end else begin
					acc_q <= acc_next;
					ovf_q <= ovf_next;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctrl.load_in) begin
			coef_q <= coefficient;
			last_q <= last_term;
		end
		if (ctrl.mul_sel != cse_pkg::MUL_NONE)
			prod_q <= mul_a * prev_q;
	end

endmodule

// ===== rtl/chebyshev_series_eval_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chebyshev_series_eval_unit: fixed-point Chebyshev series evaluator
// Microcoded sequencer over a shared multiplier datapath.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transaction per coefficient, order 0 first. x_value is taken
//            from the first transaction of a series (clamped to [-1,1]) and
//            ignored afterwards. last_term = 1 closes the series.
//   out_ch : one transaction per series: saturated sum (16 fraction bits)
//            and a sticky overflow flag for that series.
// Timing:
//   Every coefficient passes through the steps fetch, recurrence multiply,
//   T update, coefficient multiply and accumulate; the single shared
//   multiplier is why they run in sequence. in_ch.ready is high only on
//   the fetch step. The sum appears in the output register in the cycle
//   after the accumulate step of the last coefficient.
// Reset:
//   arst_n clears the sequencer, accumulator, recurrence state and output
//   valid; the block then waits for order 0.
// Stall:
//   A held result does not block the next series from starting; only the
//   accumulate step of a following last coefficient waits for the output
//   register to drain.
// ----------------------------------------------------------------------------
module chebyshev_series_eval_unit (
	input  logic      clk,
	input  logic      arst_n,
	cse_in_if.sink    in_ch,
	cse_out_if.source out_ch
);

	cse_pkg::step_t                        pc_q;
	cse_pkg::step_t                        pc_next;
	cse_pkg::ucode_t                       uw;
	cse_pkg::dp_ctrl_t                     dp_ctrl;
	logic                                  hold;
	logic                                  dp_last;
	logic signed [cse_pkg::ACC_WIDTH-1:0]  acc_next;
	logic                                  ovf_next;
	logic                                  out_valid_q;
	logic signed [cse_pkg::SUM_W-1:0]      sum_q;
	logic                                  ovf_q;
	logic                                  out_load;

	// microcode fetch and hold decision
	always_comb begin
		uw = cse_pkg::ucode_rom(pc_q);
		unique case (uw.hold)
			cse_pkg::HOLD_NO_IN:   hold = !in_ch.valid;
			cse_pkg::HOLD_OUT_BSY: hold = dp_last && out_valid_q && !out_ch.ready;
			default:               hold = 1'b0;
		endcase
		pc_next = hold ? pc_q : uw.next;

		dp_ctrl.load_in = uw.fetch && in_ch.valid;
		dp_ctrl.mul_sel = uw.mul_sel;
		dp_ctrl.t_upd   = uw.t_upd;
		dp_ctrl.acc_upd = uw.acc_upd && !hold;
		out_load        = dp_ctrl.acc_upd && dp_last;
	end

	assign in_ch.ready = uw.fetch;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= cse_pkg::STEP_FETCH;
		else
			pc_q <= pc_next;
	end

	cse_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (dp_ctrl),
		.x_value     (in_ch.x_value),
		.coefficient (in_ch.coefficient),
		.last_term   (in_ch.last_term),
		.last        (dp_last),
		.acc_next    (acc_next),
		.ovf_next    (ovf_next)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sum_q <= cse_pkg::SUM_W'(acc_next);
			ovf_q <= ovf_next;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.series_sum = sum_q;
	assign out_ch.overflow   = ovf_q;

endmodule
